FILE: rtl/u2u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

  localparam int UnitW = 16;
  localparam int ByteW = 8;
  localparam int MaxBytes = 4;
  localparam int IdxW = $clog2(MaxBytes);
  localparam int HeldW = 10;

  // Top six bits of a surrogate code unit
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag = 6'b110111;
  localparam logic [20:0] SuppBase = 21'h10000;

  // All bytes that one code unit produces, with its flags
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0] last_idx;
    logic bad;
    logic fin;
  } grp_t;

endpackage

FILE: rtl/u2u8_decode.sv
// Surrogate pairing state and UTF-8 encoding of one code unit.
module u2u8_decode
  import u2u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [UnitW-1:0] code_unit,
  input  logic             take,
  output grp_t             grp,
  output logic             emit
);

  logic [HeldW-1:0] held_high_bits;
  logic             high_pending;
  logic             discarding;
  logic [HeldW-1:0] held_high_bits_next;
  logic             high_pending_next;
  logic             discarding_next;

  logic        is_high;
  logic        is_low;
  logic        is_zero;
  logic [20:0] cp;

  assign is_high = (code_unit[15:10] == HighSurrTag);
  assign is_low  = (code_unit[15:10] == LowSurrTag);
  assign is_zero = (code_unit == '0);
  assign cp      = {1'b0, held_high_bits, code_unit[9:0]} + SuppBase;

  always_comb begin
    held_high_bits_next = held_high_bits;
    high_pending_next   = high_pending;
    discarding_next     = discarding;
    emit                = 1'b0;
    grp                 = '0;
    if (discarding) begin
      if (is_zero) begin
        discarding_next = 1'b0;
      end
    end else if (high_pending) begin
      high_pending_next   = 1'b0;
      held_high_bits_next = '0;
      emit                = 1'b1;
      if (is_low) begin
        grp.bytes[0] = {5'b11110, cp[20:18]};
        grp.bytes[1] = {2'b10, cp[17:12]};
        grp.bytes[2] = {2'b10, cp[11:6]};
        grp.bytes[3] = {2'b10, cp[5:0]};
        grp.last_idx = IdxW'(3);
      end else begin
        grp.bad = 1'b1;
        if (!is_zero) begin
          discarding_next = 1'b1;
        end
      end
    end else if (is_zero) begin
      emit    = 1'b1;
      grp.fin = 1'b1;
    end else if (is_high) begin
      held_high_bits_next = code_unit[9:0];
      high_pending_next   = 1'b1;
    end else if (is_low) begin
      emit            = 1'b1;
      grp.bad         = 1'b1;
      discarding_next = 1'b1;
    end else begin
      emit = 1'b1;
      if (code_unit[15:7] == '0) begin
        grp.bytes[0] = {1'b0, code_unit[6:0]};
      end else if (code_unit[15:11] == '0) begin
        grp.bytes[0] = {3'b110, code_unit[10:6]};
        grp.bytes[1] = {2'b10, code_unit[5:0]};
        grp.last_idx = IdxW'(1);
      end else begin
        grp.bytes[0] = {4'b1110, code_unit[15:12]};
        grp.bytes[1] = {2'b10, code_unit[11:6]};
        grp.bytes[2] = {2'b10, code_unit[5:0]};
        grp.last_idx = IdxW'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      high_pending   <= 1'b0;
      discarding     <= 1'b0;
    end else if (take) begin
      held_high_bits <= held_high_bits_next;
      high_pending   <= high_pending_next;
      discarding     <= discarding_next;
    end
  end

endmodule

FILE: rtl/u2u8_serializer.sv
// Result register that hands out one byte of a group per beat.
module u2u8_serializer
  import u2u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  grp_t             grp_in,
  input  logic             load,
  output logic             can_take,
  output logic [ByteW-1:0] out_byte,
  output logic             last_of_run,
  output logic             bad_encoding,
  output logic             string_end,
  output logic             byte_valid,
  input  logic             byte_ready
);

  grp_t            grp;
  logic            full;
  logic [IdxW-1:0] idx;
  logic            at_last;

  assign at_last  = (idx == grp.last_idx);
  assign can_take = !full || (byte_ready && at_last);

  assign byte_valid   = full;
  assign out_byte     = grp.bytes[idx];
  assign last_of_run  = at_last;
  assign bad_encoding = grp.bad;
  assign string_end   = grp.fin;

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (full && byte_ready) begin
      if (at_last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

endmodule

FILE: rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder: top level.
// The first byte of a unit is registered: it appears in the cycle after the unit's beat.
// A unit's bytes (1 to 4) leave one per beat of the one-byte result port, and a
// new unit is taken only while the result register is empty or hands out its last byte.
// Reset (synchronous): drops any held surrogate, clears discard mode, and
// empties the result register.
module utf16_to_utf8_transcoder_unit
  import u2u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [UnitW-1:0] code_unit,
  input  logic             unit_valid,
  output logic             unit_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             last_of_run,
  output logic             bad_encoding,
  output logic             string_end,
  output logic             byte_valid,
  input  logic             byte_ready
);

  grp_t grp;
  logic emit;
  logic take;
  logic can_take;

  assign unit_ready = can_take;
  assign take       = unit_valid && can_take;

  u2u8_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .code_unit (code_unit),
    .take      (take),
    .grp       (grp),
    .emit      (emit)
  );

  u2u8_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .grp_in       (grp),
    .load         (take && emit),
    .can_take     (can_take),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .bad_encoding (bad_encoding),
    .string_end   (string_end),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready)
  );

endmodule

FILE: rtl/u2u8_checker.sv
// Port-level assertions for the transcoder, bound to the top level.
module u2u8_checker
  import u2u8_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             unit_valid,
  input logic             unit_ready,
  input logic [ByteW-1:0] out_byte,
  input logic             last_of_run,
  input logic             bad_encoding,
  input logic             string_end,
  input logic             byte_valid,
  input logic             byte_ready
);

  // Error and terminator beats are single-byte runs
  a_flag_single: assert property (@(posedge clk) disable iff (rst)
    byte_valid && (bad_encoding || string_end) |-> last_of_run)
    else $error("flagged beat is not last of run");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> !(bad_encoding && string_end))
    else $error("bad_encoding and string_end together");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    byte_valid && string_end |-> out_byte == '0)
    else $error("terminator beat carries nonzero byte");

  // A stalled run keeps the unit side stalled
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |-> !(unit_valid && unit_ready))
    else $error("unit accepted while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(out_byte))
    else $error("result beat changed while stalled");

endmodule

bind utf16_to_utf8_transcoder_unit u2u8_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .unit_valid   (unit_valid),
  .unit_ready   (unit_ready),
  .out_byte     (out_byte),
  .last_of_run  (last_of_run),
  .bad_encoding (bad_encoding),
  .string_end   (string_end),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready)
);

FILE: tb/sv/tb_utf16_to_utf8_transcoder_unit.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder unit.
module tb_utf16_to_utf8_transcoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u8_pkg::*;

  localparam int StallLimit = 3000;
  localparam int UnitTarget = 350;
  localparam int DrainCycles = 16;
  localparam int HoldCycles = 300;
  localparam logic [UnitW-1:0] Terminator = '0;

  localparam logic [UnitW-1:0] DirectedUnits [24] = '{
    16'h0041, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
    16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'h0000,
    16'hDFFF, 16'h0041, 16'hD800, 16'h0000,
    16'hD83D, 16'h0041, 16'hDE00, 16'h0000,
    16'hDBFF, 16'h0000,
    16'hD800, 16'hD800, 16'h0000
  };

  typedef enum int {
    CHAR_ASCII,
    CHAR_TWO,
    CHAR_THREE,
    CHAR_PAIR
  } char_kind_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_LONE_LOW,
    FLAW_HIGH_THEN_OTHER,
    FLAW_HIGH_THEN_END,
    FLAW_NOISE
  } flaw_t;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic last;
    logic bad;
    logic fin;
  } utf8_beat_t;

  class utf8_byte_tracker;
    utf8_beat_t expected_bytes[$];
    logic [HeldW-1:0] held_bits;
    bit high_held;
    bit skipping;
    int errors;

    function new();
      held_bits = '0;
      high_held = 0;
      skipping = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    function void push_beat(logic [ByteW-1:0] b, bit last, bit bad, bit fin);
      utf8_beat_t beat;
      beat.value = b;
      beat.last = last;
      beat.bad = bad;
      beat.fin = fin;
      expected_bytes.push_back(beat);
    endfunction

    function void encode_point(logic [20:0] cp);
      logic [ByteW-1:0] seq [4];
      int n;
      if (cp < 21'h80) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n = 3;
      end else begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n = 4;
      end
      for (int i = 0; i < n; i++) push_beat(seq[i], i == n - 1, 1'b0, 1'b0);
    endfunction

    function void take_unit(logic [UnitW-1:0] w);
      bit is_high;
      bit is_low;
      is_high = (w[15:10] == HighSurrTag);
      is_low = (w[15:10] == LowSurrTag);
      if (skipping) begin
        if (w == Terminator) skipping = 0;
        return;
      end
      if (high_held) begin
        high_held = 0;
        if (is_low) begin
          encode_point({1'b0, held_bits, w[9:0]} + SuppBase);
        end else begin
          if (w != Terminator) skipping = 1;
          push_beat('0, 1'b1, 1'b1, 1'b0);
        end
        held_bits = '0;
        return;
      end
      if (w == Terminator) begin
        push_beat('0, 1'b1, 1'b0, 1'b1);
      end else if (is_high) begin
        held_bits = w[9:0];
        high_held = 1;
      end else if (is_low) begin
        skipping = 1;
        push_beat('0, 1'b1, 1'b1, 1'b0);
      end else begin
        encode_point({5'b0, w});
      end
    endfunction

    function void match_byte(logic [ByteW-1:0] b, logic last, logic bad, logic fin);
      utf8_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no beat expected, actual %h", b);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.value) begin
        $error("out_byte: expected %h, actual %h", want.value, b);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, actual %b", want.last, last);
        errors++;
      end
      if (bad !== want.bad) begin
        $error("bad_encoding: expected %b, actual %b", want.bad, bad);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("string_end: expected %b, actual %b", want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic [UnitW-1:0] code_unit;
  logic unit_valid;
  logic unit_ready;
  logic [ByteW-1:0] out_byte;
  logic last_of_run;
  logic bad_encoding;
  logic string_end;
  logic byte_valid;
  logic byte_ready;

  utf8_byte_tracker tracker = new();
  int units_in = 0;
  int units_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  utf16_to_utf8_transcoder_unit u_top (
    .clk(clk),
    .rst(rst),
    .code_unit(code_unit),
    .unit_valid(unit_valid),
    .unit_ready(unit_ready),
    .out_byte(out_byte),
    .last_of_run(last_of_run),
    .bad_encoding(bad_encoding),
    .string_end(string_end),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) begin
        tracker.match_byte(out_byte, last_of_run, bad_encoding, string_end);
      end
      if (unit_valid && unit_ready) begin
        tracker.take_unit(code_unit);
        units_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (unit_valid && unit_ready) || (byte_valid && byte_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: segments of differing stall patterns, one long hold-off.
  initial begin : byte_sink
    int mode;
    int span;
    bit held_once;
    held_once = 0;
    byte_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_once && units_in >= 60) begin
        held_once = 1;
        byte_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0: byte_ready <= 1'b1;
          1: byte_ready <= ($urandom_range(0, 1) != 0);
          2: byte_ready <= (i % 4 == 0);
          default: byte_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_unit(input logic [UnitW-1:0] w);
    if (burst_left == 0) begin
      unit_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    code_unit <= w;
    unit_valid <= 1'b1;
    @(posedge clk);
    while (!unit_ready) @(posedge clk);
    units_sent++;
    @(negedge clk);
  endtask

  function automatic logic [UnitW-1:0] rand_bmp(char_kind_t kind);
    logic [UnitW-1:0] w;
    case (kind)
      CHAR_ASCII: w = UnitW'($urandom_range(16'h0001, 16'h007F));
      CHAR_TWO:   w = UnitW'($urandom_range(16'h0080, 16'h07FF));
      default: begin
        if ($urandom_range(0, 3) == 0) w = UnitW'($urandom_range(16'hE000, 16'hFFFF));
        else w = UnitW'($urandom_range(16'h0800, 16'hD7FF));
      end
    endcase
    return w;
  endfunction

  task automatic send_char();
    char_kind_t kind;
    logic [9:0] hi_bits;
    logic [9:0] lo_bits;
    kind = char_kind_t'($urandom_range(0, 3));
    if (kind == CHAR_PAIR) begin
      hi_bits = 10'($urandom_range(0, 1023));
      lo_bits = 10'($urandom_range(0, 1023));
      send_unit({HighSurrTag, hi_bits});
      send_unit({LowSurrTag, lo_bits});
    end else begin
      send_unit(rand_bmp(kind));
    end
  endtask

  task automatic send_flaw(input flaw_t flaw);
    logic [9:0] bits;
    logic [UnitW-1:0] other;
    bits = 10'($urandom_range(0, 1023));
    case (flaw)
      FLAW_LONE_LOW: send_unit({LowSurrTag, bits});
      FLAW_HIGH_THEN_OTHER: begin
        send_unit({HighSurrTag, bits});
        if ($urandom_range(0, 3) == 0) begin
          other = {HighSurrTag, 10'($urandom_range(0, 1023))};
        end else begin
          other = rand_bmp(char_kind_t'($urandom_range(0, 2)));
        end
        send_unit(other);
      end
      FLAW_NOISE: begin
        repeat ($urandom_range(1, 4)) send_unit(UnitW'($urandom));
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int len;
    int flaw_at;
    flaw_t flaw;
    rst = 1'b1;
    unit_valid = 1'b0;
    code_unit = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedUnits[i]) send_unit(DirectedUnits[i]);

    while (units_sent < UnitTarget) begin
      len = $urandom_range(0, 10);
      flaw_at = $urandom_range(0, len);
      case ($urandom_range(0, 19))
        0, 1:    flaw = FLAW_LONE_LOW;
        2, 3:    flaw = FLAW_HIGH_THEN_OTHER;
        4, 5:    flaw = FLAW_HIGH_THEN_END;
        6:       flaw = FLAW_NOISE;
        default: flaw = FLAW_NONE;
      endcase
      for (int k = 0; k <= len; k++) begin
        if (k == flaw_at && flaw != FLAW_HIGH_THEN_END) send_flaw(flaw);
        if (k < len) send_char();
      end
      if (flaw == FLAW_HIGH_THEN_END) begin
        send_unit({HighSurrTag, 10'($urandom_range(0, 1023))});
      end
      send_unit(Terminator);
    end
    unit_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/u2u8_pkg.sv
rtl/u2u8_decode.sv
rtl/u2u8_serializer.sv
rtl/utf16_to_utf8_transcoder_unit.sv
rtl/u2u8_checker.sv
tb/sv/tb_utf16_to_utf8_transcoder_unit.sv
